/* src/sgsf_pkg.sv */
// Shared types and constants for the spread-gated smoothing filter.
// Used by every module of the block; depends on nothing.
package sgsf_pkg;

    // Sample and window geometry
    localparam int SAMPLE_W  = 16;
    localparam int WIN_SIZE  = 3;
    localparam int POS_W     = (WIN_SIZE > 1) ? $clog2(WIN_SIZE) : 1;
    localparam int WIN_SQ    = WIN_SIZE * WIN_SIZE;
    localparam int SQ_W      = 2 * SAMPLE_W;
    // Wide enough for n^2 * limit^2 and for the sum of all pairwise squares
    localparam int CMP_W     = SQ_W + $clog2(WIN_SQ);

    // Configuration port
    localparam int CFG_IDX_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LOW_LIMIT    = 2'd0,
        REG_HIGH_LIMIT   = 2'd1,
        REG_SPREAD_LIMIT = 2'd2
    } cfg_index_t;

    // Reset values
    localparam logic [SAMPLE_W-1:0] RESET_LOW_LIMIT    = 16'd850;
    localparam logic [SAMPLE_W-1:0] RESET_HIGH_LIMIT   = 16'd2900;
    localparam logic [SAMPLE_W-1:0] RESET_SPREAD_LIMIT = 16'd250;
    localparam logic [SAMPLE_W-1:0] RESET_HELD         = 16'd850;
    localparam logic [SQ_W-1:0]     RESET_SPREAD_SQ    =
        SQ_W'(RESET_SPREAD_LIMIT) * SQ_W'(RESET_SPREAD_LIMIT);
    localparam logic [CMP_W-1:0]    RESET_LIMIT_TERM   =
        CMP_W'(RESET_SPREAD_SQ) * CMP_W'(WIN_SQ);

    typedef logic [SAMPLE_W-1:0] sample_t;
    typedef logic [WIN_SIZE-1:0][SAMPLE_W-1:0] sample_win_t;

    // Configuration as seen by the datapath
    typedef struct packed {
        sample_t            low_limit;
        sample_t            high_limit;
        logic [CMP_W-1:0]   limit_term;   // n^2 * spread_limit^2
    } cfg_t;

endpackage

/* src/spread_gated_smoothing_filter_unit.sv */
// Top level of the spread-gated smoothing filter: input register, gating and
// averaging datapath, result register. Uses sgsf_pkg, sgsf_cfg, sgsf_spread.

// One raw sample in, one smoothed value out. Every sample enters a ring of the
// last three samples; a sample strictly between the low and high limits is
// taken when the window's standard deviation is within the spread limit,
// otherwise the last taken value is reused. The output is the floor of the
// mean of the previous output and that value. Throughput is one transaction
// per clock; a result is offered from the result register after passing the
// input register, and a stalled output holds the pipeline.
// Register writes must be made while no transaction is in flight; a spread
// limit write passes the squared-limit register, then the limit-term register,
// before it reaches the datapath. There is no clearing pass after reset.
module spread_gated_smoothing_filter_unit (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [sgsf_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [sgsf_pkg::SAMPLE_W-1:0]       cfg_wdata,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [sgsf_pkg::SAMPLE_W-1:0]       s_raw_sample,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [sgsf_pkg::SAMPLE_W-1:0]       m_smoothed_value
);
    import sgsf_pkg::*;

    cfg_t               cfg;
    logic               in_valid_reg;
    sample_t            in_sample_reg;
    logic               out_valid_reg;
    sample_t            out_value_reg;
    sample_win_t        window_reg;
    sample_win_t        window_next;
    logic [POS_W-1:0]   wr_pos_reg;
    logic [POS_W-1:0]   wr_pos_next;
    sample_t            held_reg;
    sample_t            held_next;
    sample_t            prev_reg;
    sample_t            prev_next;
    logic               advance;
    logic               process;
    logic               too_wide;
    logic               in_range;
    logic               take;
    sample_t            chosen;
    logic [SAMPLE_W:0]  avg_sum;

    sgsf_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // Handshake: the result register frees the input stage
    assign advance = !out_valid_reg || m_ready;
    assign s_ready = !in_valid_reg || advance;
    assign process = in_valid_reg && advance;

    // Ring update with the sample in the input register
    always_comb begin
        for (int k = 0; k < WIN_SIZE; k++) begin
            window_next[k] = (wr_pos_reg == POS_W'(k)) ? in_sample_reg : window_reg[k];
        end
        wr_pos_next = (wr_pos_reg >= POS_W'(WIN_SIZE - 1)) ? '0 : wr_pos_reg + 1'b1;
    end

    sgsf_spread u_spread (
        .window     (window_next),
        .limit_term (cfg.limit_term),
        .too_wide   (too_wide)
    );

    // Gating and half-weight average
    assign in_range  = (in_sample_reg < cfg.high_limit) && (in_sample_reg > cfg.low_limit);
    assign take      = in_range && !too_wide;
    assign chosen    = take ? in_sample_reg : held_reg;
    assign held_next = chosen;
    assign avg_sum   = {1'b0, prev_reg} + {1'b0, chosen};
    assign prev_next = avg_sum[SAMPLE_W:1];

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
        if (s_valid && s_ready) begin
            in_sample_reg <= s_raw_sample;
        end
    end

    // Filter state and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            window_reg    <= '0;
            wr_pos_reg    <= '0;
            held_reg      <= RESET_HELD;
            prev_reg      <= RESET_HELD;
        end else begin
            if (advance) begin
                out_valid_reg <= in_valid_reg;
            end
            if (process) begin
                window_reg <= window_next;
                wr_pos_reg <= wr_pos_next;
                held_reg   <= held_next;
                prev_reg   <= prev_next;
            end
        end
        if (process) begin
            out_value_reg <= prev_next;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_smoothed_value = out_value_reg;

endmodule

/* src/sgsf_cfg.sv */
// Configuration registers of the spread-gated smoothing filter.
// Keeps the limits and the pre-squared spread threshold; uses sgsf_pkg.
module sgsf_cfg (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [sgsf_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [sgsf_pkg::SAMPLE_W-1:0]       cfg_wdata,
    output sgsf_pkg::cfg_t                      cfg
);
    import sgsf_pkg::*;

    sample_t            low_reg;
    sample_t            high_reg;
    logic [SQ_W-1:0]    spread_sq_reg;
    logic [CMP_W-1:0]   limit_term_reg;
    logic [CMP_W-1:0]   limit_term_next;

    // Scale the squared limit by n^2; registered after the squaring
    assign limit_term_next = CMP_W'(spread_sq_reg) * CMP_W'(WIN_SQ);

    // Register writes; unknown indices are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            low_reg        <= RESET_LOW_LIMIT;
            high_reg       <= RESET_HIGH_LIMIT;
            spread_sq_reg  <= RESET_SPREAD_SQ;
            limit_term_reg <= RESET_LIMIT_TERM;
        end else begin
            limit_term_reg <= limit_term_next;
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_LOW_LIMIT:    low_reg  <= cfg_wdata;
                    REG_HIGH_LIMIT:   high_reg <= cfg_wdata;
                    REG_SPREAD_LIMIT: spread_sq_reg <=
                        SQ_W'(cfg_wdata) * SQ_W'(cfg_wdata);
                    default: ;
                endcase
            end
        end
    end

    assign cfg.low_limit  = low_reg;
    assign cfg.high_limit = high_reg;
    assign cfg.limit_term = limit_term_reg;

endmodule

/* src/sgsf_spread.sv */
// Window spread test of the spread-gated smoothing filter.
// n*sum(x^2) - sum(x)^2 is formed as the sum of pairwise squared differences.
// Uses sgsf_pkg.
module sgsf_spread (
    input  sgsf_pkg::sample_win_t           window,
    input  logic [sgsf_pkg::CMP_W-1:0]      limit_term,
    output logic                            too_wide
);
    import sgsf_pkg::*;

    logic [CMP_W-1:0] spread_sum;

    // One squarer per pair of window entries, summed
    always_comb begin
        logic [SAMPLE_W-1:0] diff;
        logic [SQ_W-1:0]     sq;
        spread_sum = '0;
        diff       = '0;
        sq         = '0;
        for (int i = 0; i < WIN_SIZE; i++) begin
            for (int j = i + 1; j < WIN_SIZE; j++) begin
                diff = (window[i] >= window[j]) ? (window[i] - window[j])
                                                : (window[j] - window[i]);
                sq   = SQ_W'(diff) * SQ_W'(diff);
                spread_sum = spread_sum + CMP_W'(sq);
            end
        end
    end

    assign too_wide = spread_sum > limit_term;

endmodule

/* bench/spread_gated_smoothing_filter_unit_test.sv */
// Self-checking bench for spread_gated_smoothing_filter_unit: queue-fed driver,
// clocked monitor and an in-bench predictor of the gated smoothing datapath.
// Depends on sgsf_pkg and the filter top level only.
`timescale 1ns / 1ps

module spread_gated_smoothing_filter_unit_test;
    import sgsf_pkg::*;

    localparam int                   SETTLE_CYCLES = 3;
    localparam int                   DRAIN_CYCLES  = 4;
    localparam int                   LONG_HOLD     = 64;
    localparam int                   TIMEOUT_NS    = 1_000_000;
    // Index with no register behind it; writes to it must be ignored
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED    = 2'd3;

    typedef struct {
        sample_t sample;
        sample_t value;
    } smoothed_entry_t;

    // Block ports
    logic                 aclk;
    logic                 aresetn          = 1'b0;
    logic                 cfg_wr_en        = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index        = '0;
    sample_t              cfg_wdata        = '0;
    logic                 s_valid          = 1'b0;
    logic                 s_ready;
    sample_t              s_raw_sample     = '0;
    logic                 m_valid;
    logic                 m_ready          = 1'b0;
    sample_t              m_smoothed_value;

    // Predictor state
    sample_t         limit_low    = RESET_LOW_LIMIT;
    sample_t         limit_high   = RESET_HIGH_LIMIT;
    sample_t         limit_spread = RESET_SPREAD_LIMIT;
    sample_t         ring_model [WIN_SIZE] = '{default: '0};
    int              ring_pos     = 0;
    sample_t         held_value   = RESET_HELD;
    sample_t         last_output  = RESET_HELD;

    // Stimulus and scoreboard
    sample_t         pending_samples [$];
    smoothed_entry_t expected_outputs [$];
    smoothed_entry_t oldest;
    int              error_count  = 0;
    logic            sample_taken = 1'b0;

    // Traffic shaping
    logic            sender_gaps     = 1'b0;
    logic            receiver_stalls = 1'b0;
    logic            hold_request    = 1'b0;
    logic            hold_served     = 1'b0;
    int              hold_left       = 0;
    int              burst_left      = 0;
    int              gap_left        = 0;
    int              pattern_left    = 0;
    logic            ready_phase     = 1'b1;

    // Limits, startup window with zeros, steady runs, a jump and extreme and alternating bit patterns
    sample_t directed_samples [25] = '{
        16'd0,    16'd65535, 16'h5555, 16'hAAAA, 16'd850,
        16'd851,  16'd2899,  16'd2900, 16'd1200, 16'd1200,
        16'd1200, 16'd1250,  16'd1300, 16'd1900, 16'd1200,
        16'd1200, 16'd2899,  16'd2899, 16'd2899, 16'd851,
        16'd851,  16'd851,   16'd3000, 16'd1000, 16'd1000
    };

    spread_gated_smoothing_filter_unit u_top (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_raw_sample     (s_raw_sample),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_smoothed_value (m_smoothed_value)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("spread_gated_smoothing_filter_unit test failed");
        $finish;
    end

    // Predict one result: ring update, range and spread gating, half-weight mean
    function automatic sample_t smooth_sample(input sample_t x);
        logic [63:0] s1;
        logic [63:0] s2;
        logic [63:0] n;
        logic [63:0] lim;
        logic        too_wide;
        sample_t     chosen;
        s1  = '0;
        s2  = '0;
        n   = 64'(WIN_SIZE);
        lim = 64'(limit_spread);
        ring_model[ring_pos] = x;
        ring_pos = (ring_pos == WIN_SIZE - 1) ? 0 : ring_pos + 1;
        for (int i = 0; i < WIN_SIZE; i++) begin
            s1 = s1 + 64'(ring_model[i]);
            s2 = s2 + 64'(ring_model[i]) * 64'(ring_model[i]);
        end
        too_wide = (n * s2 - s1 * s1) > (n * n * lim * lim);
        if (x < limit_high && x > limit_low && !too_wide) begin
            held_value = x;
            chosen     = x;
        end else begin
            chosen = held_value;
        end
        last_output = sample_t'((17'(last_output) + 17'(chosen)) >> 1);
        return last_output;
    endfunction

    task automatic report_mismatch(input string what, input sample_t sample,
                                   input sample_t want, input sample_t got);
        $display("%0t ERROR %s: sample %0d expected %0d got %0d",
                 $realtime, what, sample, want, got);
        error_count++;
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] index,
                                  input sample_t value);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= index;
        cfg_wdata <= value;
        case (index)
            REG_LOW_LIMIT:    limit_low    = value;
            REG_HIGH_LIMIT:   limit_high   = value;
            REG_SPREAD_LIMIT: limit_spread = value;
            default: ;
        endcase
    endtask

    // Write all registers plus the unused index, then let the spread term settle
    task automatic configure(input sample_t low, input sample_t high,
                             input sample_t spread, input sample_t junk);
        write_register(REG_LOW_LIMIT, low);
        write_register(REG_UNUSED, junk);
        write_register(REG_HIGH_LIMIT, high);
        write_register(REG_SPREAD_LIMIT, spread);
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic wait_drained;
        while (pending_samples.size() != 0 || s_valid || expected_outputs.size() != 0)
            @(posedge aclk);
    endtask

    // Runs of samples around a centre within the limits (anywhere when the limits leave no room), with some outliers
    task automatic queue_samples(input int count, input int jitter, input int outlier_pct);
        int run_left;
        int centre;
        int v;
        run_left = 0;
        centre   = 0;
        for (int i = 0; i < count; i++) begin
            if (run_left == 0) begin
                run_left = $urandom_range(3, 12);
                if (int'(limit_high) > int'(limit_low) + 1)
                    centre = $urandom_range(int'(limit_low) + 1, int'(limit_high) - 1);
                else
                    centre = $urandom_range(0, 65535);
            end
            run_left--;
            if ($urandom_range(0, 99) < outlier_pct) begin
                case ($urandom_range(0, 3))
                    0: v = $urandom_range(0, 65535);
                    1: v = int'(limit_low);
                    2: v = int'(limit_high);
                    default: v = ($urandom_range(0, 1) != 0) ? 65535 : 0;
                endcase
            end else begin
                v = centre + int'($urandom_range(0, 2 * jitter)) - jitter;
                if (v < 0)
                    v = 0;
                if (v > 65535)
                    v = 65535;
            end
            pending_samples.push_back(sample_t'(v));
        end
    endtask

    // Sender: bursts of random length with random gaps between them when sender_gaps is set
    always @(negedge aclk) begin
        if (!s_valid || sample_taken) begin
            if (gap_left > 0) begin
                gap_left--;
                s_valid <= 1'b0;
            end else if (pending_samples.size() != 0) begin
                s_valid      <= 1'b1;
                s_raw_sample <= pending_samples.pop_front();
                if (sender_gaps) begin
                    if (burst_left == 0) begin
                        burst_left = $urandom_range(1, 16);
                        gap_left   = $urandom_range(1, 8);
                    end else begin
                        burst_left--;
                    end
                end
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Receiver: own stall pattern when receiver_stalls is set, plus one long hold-off on request
    always @(negedge aclk) begin
        if (hold_request && !hold_served) begin
            hold_left   = LONG_HOLD;
            hold_served = 1'b1;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if (!receiver_stalls) begin
            m_ready <= 1'b1;
        end else begin
            if (pattern_left == 0) begin
                ready_phase  = !ready_phase;
                pattern_left = ready_phase ? $urandom_range(1, 12) : $urandom_range(1, 6);
            end
            pattern_left--;
            m_ready <= ready_phase;
        end
    end

    // Monitor: check results in order, predict each accepted transaction
    always @(posedge aclk) begin
        sample_taken = aresetn && s_valid && s_ready;
        if (aresetn && m_valid && m_ready) begin
            if (expected_outputs.size() == 0) begin
                report_mismatch("unexpected result", '0, '0, m_smoothed_value);
            end else begin
                oldest = expected_outputs.pop_front();
                if (m_smoothed_value !== oldest.value)
                    report_mismatch("smoothed_value", oldest.sample, oldest.value,
                                    m_smoothed_value);
            end
        end
        if (sample_taken)
            expected_outputs.push_back('{sample: s_raw_sample,
                                         value: smooth_sample(s_raw_sample)});
    end

    initial begin
        repeat (2) @(negedge aclk);
        aresetn <= 1'b1;

        // Directed samples on reset settings, startup window included
        receiver_stalls = 1'b1;
        foreach (directed_samples[i])
            pending_samples.push_back(directed_samples[i]);
        wait_drained();

        // Widest limits and largest spread
        configure(16'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        sender_gaps = 1'b1;
        queue_samples(120, 20000, 20);
        wait_drained();

        // Zero spread: only a window of equal samples passes
        configure(16'd500, 16'd4000, 16'd0, 16'h0000);
        queue_samples(100, 0, 15);
        wait_drained();

        // Crossed limits; long receiver hold-off while the sender keeps going
        configure(16'd3000, 16'd1000, 16'd300, 16'h5A5A);
        sender_gaps     = 1'b0;
        receiver_stalls = 1'b0;
        queue_samples(60, 300, 10);
        hold_request = 1'b1;
        wait_drained();
        queue_samples(40, 300, 10);
        wait_drained();

        // Equal limits
        configure(16'd2000, 16'd2000, 16'hFFFF, 16'hA5A5);
        receiver_stalls = 1'b1;
        queue_samples(60, 500, 10);
        wait_drained();

        // Random settings, spread jitter around the spread limit
        for (int k = 0; k < 4; k++) begin : random_phase
            int   low;
            int   spread;
            low    = $urandom_range(0, 3000);
            spread = $urandom_range(0, 1500);
            configure(sample_t'(low), sample_t'(low + $urandom_range(2, 20000)),
                      sample_t'(spread), sample_t'($urandom_range(0, 65535)));
            sender_gaps     = 1'($urandom_range(0, 1));
            receiver_stalls = 1'($urandom_range(0, 1));
            queue_samples(100, $urandom_range(0, 2 * spread + 5), 15);
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (error_count == 0)
            $display("spread_gated_smoothing_filter_unit test passed");
        else
            $display("spread_gated_smoothing_filter_unit test failed");
        $finish;
    end

endmodule
